@@ hdl/drr_pkg.sv @@
// Package for the deficit round robin scheduler: item types, constants and
// the saturating deficit add. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package drr_pkg;

   localparam int NUM_CLASSES_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int QUANT_W         = 16;
   localparam int DEFICIT_W       = 32;
   localparam int CSR_IDX_W       = 4;
   localparam int CSR_REGS        = 8;
   localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd1500;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [2:0]  class_id;
      logic [15:0] packet_length;
      logic [15:0] packet_handle;
   } req_type;

   typedef struct packed {
      logic        enqueue_accepted;
      logic        packet_valid;
      logic [3:0]  served_class;
      logic [15:0] served_length;
      logic [15:0] served_handle;
   } rsp_type;

   // Handshake between the front queue and the engine.
   typedef struct packed {
      logic valid;
      logic pop;
   } link_type;

   function automatic logic [DEFICIT_W-1:0] sat_add(input logic [DEFICIT_W-1:0] a,
                                                     input logic [QUANT_W-1:0] q);
      logic [DEFICIT_W:0] s;
      s = {1'b0, a} + {{(DEFICIT_W-QUANT_W+1){1'b0}}, q};
      return s[DEFICIT_W] ? {DEFICIT_W{1'b1}} : s[DEFICIT_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/drr_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module drr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hdl/drr_front.sv @@
// Front of the scheduler: a two entry queue that takes request items and
// holds them for the engine. Depends on drr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire drr_pkg::req_type req_data,
   input  wire logic             pop,
   output drr_pkg::link_type     link,
   output drr_pkg::req_type      item
);
   import drr_pkg::*;

   req_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign item      = slot_ff[rd_ptr_ff];
   assign link.valid = (fill_ff != 2'd0);
   assign link.pop   = pop && link.valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = link.pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, link.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/drr_engine.sv @@
// Back end of the scheduler: class FIFO pointers, deficit counters, the
// round robin walk and the result register. Depends on drr_pkg and drr_ram.
`timescale 1ns / 1ps
`default_nettype none

module drr_engine #(
   parameter int NUM_CLASSES = drr_pkg::NUM_CLASSES_DEF,
   parameter int QUEUE_DEPTH = drr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire drr_pkg::link_type                       link,
   input  wire drr_pkg::req_type                        item,
   output logic                                         pop,
   input  wire logic [NUM_CLASSES-1:0][drr_pkg::QUANT_W-1:0] quantum,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output drr_pkg::rsp_type                             rsp_data
);
   import drr_pkg::*;

   localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W  = $clog2(NUM_CLASSES + 2);
   localparam int ADDR_W = CIDX_W + PTR_W;
   localparam logic [CIDX_W-1:0] LAST_CLASS = CIDX_W'(NUM_CLASSES - 1);
   localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(QUEUE_DEPTH);
   localparam logic [POS_W-1:0]  ROUND_END  = POS_W'(NUM_CLASSES);
   localparam logic [3:0]        NONE_CODE  = 4'(NUM_CLASSES);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_READ  = 3'b010,
      S_CHECK = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [PTR_W-1:0]       head_ff [NUM_CLASSES];
   logic [PTR_W-1:0]       head_in [NUM_CLASSES];
   logic [PTR_W-1:0]       tail_ff [NUM_CLASSES];
   logic [PTR_W-1:0]       tail_in [NUM_CLASSES];
   logic [CNT_W-1:0]       cnt_ff  [NUM_CLASSES];
   logic [CNT_W-1:0]       cnt_in  [NUM_CLASSES];
   logic [DEFICIT_W-1:0]   def_ff  [NUM_CLASSES];
   logic [DEFICIT_W-1:0]   def_in  [NUM_CLASSES];
   logic [DEFICIT_W-1:0]   work_ff [NUM_CLASSES];
   logic [DEFICIT_W-1:0]   work_in [NUM_CLASSES];
   logic                   act_valid_ff, act_valid_in;
   logic [CIDX_W-1:0]      act_ff, act_in;
   logic [CIDX_W-1:0]      cur_ff, cur_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   prog_ff, prog_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [31:0]            rd_data;

   logic                   any_queued;
   logic [CIDX_W-1:0]      enq_cls;
   logic                   enq_ok;
   logic [CIDX_W-1:0]      nxt;
   logic [15:0]            head_len;
   logic                   nonempty;
   logic                   fits;
   logic                   prog_now;
   rsp_type                none_rsp;

   drr_ram #(
      .WIDTH (32),
      .DEPTH (2 ** ADDR_W)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    ({item.packet_length, item.packet_handle}),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      any_queued = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         any_queued = any_queued | (cnt_ff[c] != '0);
      end
      enq_cls  = CIDX_W'(item.class_id);
      enq_ok   = (int'(item.class_id) < NUM_CLASSES) && (cnt_ff[enq_cls] < FULL_CNT);
      nxt      = (cur_ff == LAST_CLASS) ? '0 : cur_ff + 1'b1;
      head_len = rd_data[31:16];
      nonempty = (cnt_ff[cur_ff] != '0);
      fits     = nonempty && (work_ff[cur_ff] >= {16'd0, head_len});
      prog_now = prog_ff || ((pos_ff != '0) && nonempty && (quantum[cur_ff] != '0));
      none_rsp = '{enqueue_accepted: 1'b0, packet_valid: 1'b0, served_class: NONE_CODE,
                   served_length: 16'd0, served_handle: 16'd0};
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      def_in       = def_ff;
      work_in      = work_ff;
      act_valid_in = act_valid_ff;
      act_in       = act_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      prog_in      = prog_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = {enq_cls, tail_ff[enq_cls]};
      rd_en        = 1'b0;
      rd_addr      = {cur_ff, head_ff[cur_ff]};

      case (state_ff)
         S_IDLE: begin
            if (link.valid && !rsp_valid_ff) begin
               if (item.operation == OP_ENQUEUE) begin
                  pop          = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in       = none_rsp;
                  if (enq_ok) begin
                     wr_en                     = 1'b1;
                     tail_in[enq_cls]          = (tail_ff[enq_cls] == LAST_PTR) ? '0
                                                 : tail_ff[enq_cls] + 1'b1;
                     cnt_in[enq_cls]           = cnt_ff[enq_cls] + 1'b1;
                     rsp_in.enqueue_accepted   = 1'b1;
                  end
               end else if (!any_queued) begin
                  pop          = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in       = none_rsp;
               end else begin
                  work_in = def_ff;
                  pos_in  = '0;
                  prog_in = 1'b0;
                  if (act_valid_ff) begin
                     cur_in = act_ff;
                  end else begin
                     cur_in     = '0;
                     work_in[0] = sat_add(def_ff[0], quantum[0]);
                  end
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (fits) begin
               def_in               = work_ff;
               def_in[cur_ff]       = work_ff[cur_ff] - {16'd0, head_len};
               head_in[cur_ff]      = (head_ff[cur_ff] == LAST_PTR) ? '0
                                      : head_ff[cur_ff] + 1'b1;
               cnt_in[cur_ff]       = cnt_ff[cur_ff] - 1'b1;
               act_valid_in         = 1'b1;
               act_in               = cur_ff;
               pop                  = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_in.enqueue_accepted = 1'b0;
               rsp_in.packet_valid  = 1'b1;
               rsp_in.served_class  = 4'(cur_ff);
               rsp_in.served_length = head_len;
               rsp_in.served_handle = rd_data[15:0];
               state_in             = S_IDLE;
            end else if ((pos_ff == ROUND_END) && !prog_now) begin
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = none_rsp;
               state_in     = S_IDLE;
            end else begin
               work_in[nxt] = sat_add(work_ff[nxt], quantum[nxt]);
               cur_in       = nxt;
               pos_in       = (pos_ff == ROUND_END) ? pos_ff : pos_ff + 1'b1;
               prog_in      = prog_now;
               state_in     = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         act_valid_ff <= 1'b0;
         act_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c] <= '0;
            tail_ff[c] <= '0;
            cnt_ff[c]  <= '0;
            def_ff[c]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         act_valid_ff <= act_valid_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         def_ff       <= def_in;
      end
      work_ff <= work_in;
      cur_ff  <= cur_in;
      pos_ff  <= pos_in;
      prog_ff <= prog_in;
      rsp_ff  <= rsp_in;
   end

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.enqueue_accepted && rsp_ff.packet_valid))
      else $error("result marks both an enqueue and a served packet");

   a_served_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.packet_valid) |-> (rsp_ff.served_class < NONE_CODE))
      else $error("served packet carries the no-class code");

   a_pop_done: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("item retired without a result");

   a_walk_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> $past(rd_en))
      else $error("head checked without a store read");

endmodule

`default_nettype wire

@@ hdl/deficit_round_robin_scheduler.sv @@
// Top level of the deficit round robin scheduler: quantum registers, front
// queue and engine. Depends on drr_pkg, drr_front, drr_engine and drr_ram.
`timescale 1ns / 1ps
`default_nettype none

// Deficit round robin scheduler over NUM_CLASSES class FIFOs of QUEUE_DEPTH
// packets each. Every request item yields exactly one result item. An enqueue
// stores length and handle in its class FIFO and reports whether it was taken.
// A dequeue walks the classes round robin, adding each visited class's
// quantum, until a head packet fits its deficit, and returns that packet; it
// returns no packet, with served_class equal to NUM_CLASSES, when all FIFOs
// are empty or a full round makes no progress. Request items go into a two
// entry queue, so the block takes new items while the engine works and while
// a result waits in the output register. A dequeue passes through a read and
// a check state for each class visited, because each visit reads the head
// entry from the packet store, whose read data is registered; the walk visits
// about NUM_CLASSES times ceil(length / quantum) classes in the worst case,
// and just one or a few classes when deficits are already built up. The user
// must write quantum registers through the csr port only while the block is
// idle; the block does not enforce it. Indexes beyond the class count are ignored.

module deficit_round_robin_scheduler #(
   parameter int NUM_CLASSES = drr_pkg::NUM_CLASSES_DEF,
   parameter int QUEUE_DEPTH = drr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire drr_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output drr_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [drr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [drr_pkg::QUANT_W-1:0]       csr_wdata
);
   import drr_pkg::*;

   // One quantum per class; classes beyond the register list keep the reset value.
   logic [NUM_CLASSES-1:0][QUANT_W-1:0] quantum_ff;
   link_type link;
   req_type  item;
   logic     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            quantum_ff[c] <= QUANTUM_RESET;
         end
      end else begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            if (csr_we && (c < CSR_REGS) && (int'(csr_index) == c)) begin
               quantum_ff[c] <= csr_wdata;
            end
         end
      end
   end

   drr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pop       (pop),
      .link      (link),
      .item      (item)
   );

   drr_engine #(
      .NUM_CLASSES (NUM_CLASSES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .link      (link),
      .item      (item),
      .pop       (pop),
      .quantum   (quantum_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ tb/drr_checker.sv @@
// Scoreboard for the deficit round robin scheduler: watches the request,
// result and register ports, predicts each result and compares it.
// Depends on drr_pkg.
`timescale 1ns / 1ps

module drr_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire drr_pkg::req_type              req_data,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire drr_pkg::rsp_type              rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [drr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [drr_pkg::QUANT_W-1:0]   csr_wdata,
   output int                                 fail_count,
   output int                                 outstanding
);
   import drr_pkg::*;

   localparam int NCLS  = NUM_CLASSES_DEF;
   localparam int DEPTH = QUEUE_DEPTH_DEF;
   localparam logic [3:0] NO_CLASS = 4'(NCLS);

   logic [31:0]        credit [NCLS];
   logic [15:0]        weight [NCLS];
   logic [3:0]         last_served;
   logic [31:0]        fifo_mem [NCLS][DEPTH];
   int                 rd_ptr [NCLS];
   int                 wr_ptr [NCLS];
   int                 fill [NCLS];
   rsp_type            pending_results [$];

   function automatic logic [31:0] clamp_add(input longint unsigned a,
                                              input longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   task automatic report(input string what, input longint unsigned got,
                         input longint unsigned want);
      $display("ERROR t=%0t %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // Serves one dequeue. The walk is solved in closed form: for each class
   // we find the walk position at which its head first fits.
   function automatic rsp_type serve_next();
      rsp_type         r;
      longint unsigned start_d [NCLS];
      longint unsigned len, off, rounds, pos, win_pos, visits;
      int              start, win;
      bit              busy;
      r = '{enqueue_accepted: 1'b0, packet_valid: 1'b0, served_class: NO_CLASS,
            served_length: 16'd0, served_handle: 16'd0};
      busy = 1'b0;
      for (int c = 0; c < NCLS; c++) begin
         start_d[c] = credit[c];
         if (fill[c] != 0) busy = 1'b1;
      end
      if (!busy) return r;
      if (last_served < NO_CLASS) begin
         start = last_served;
      end else begin
         start = 0;
         start_d[0] = clamp_add(start_d[0], weight[0]);
      end
      win = NCLS;
      win_pos = 0;
      for (int c = 0; c < NCLS; c++) begin
         if (fill[c] == 0) continue;
         len = fifo_mem[c][rd_ptr[c]] >> 16;
         off = (c + NCLS - start) % NCLS;
         if (off == 0) begin
            // The class we resume on needs no fresh quantum if it still fits.
            if (start_d[c] >= len) begin
               win = c;
               win_pos = 0;
               break;
            end
            off = NCLS;
         end
         if (start_d[c] >= len) rounds = 1;
         else if (weight[c] == 0) continue;
         else rounds = (len - start_d[c] + weight[c] - 1) / weight[c];
         pos = off + (rounds - 1) * NCLS;
         if (win == NCLS || pos < win_pos) begin
            win = c;
            win_pos = pos;
         end
      end
      if (win == NCLS) return r;
      for (int c = 0; c < NCLS; c++) begin
         off = (c + NCLS - start) % NCLS;
         if (off == 0) off = NCLS;
         visits = (off > win_pos) ? 0 : (win_pos - off) / NCLS + 1;
         credit[c] = clamp_add(start_d[c], visits * weight[c]);
      end
      r.packet_valid  = 1'b1;
      r.served_class  = 4'(win);
      r.served_length = fifo_mem[win][rd_ptr[win]][31:16];
      r.served_handle = fifo_mem[win][rd_ptr[win]][15:0];
      rd_ptr[win] = (rd_ptr[win] + 1) % DEPTH;
      fill[win]--;
      credit[win] -= r.served_length;
      last_served = 4'(win);
      return r;
   endfunction

   function automatic rsp_type store_packet(input req_type it);
      rsp_type r;
      r = '{enqueue_accepted: 1'b0, packet_valid: 1'b0, served_class: NO_CLASS,
            served_length: 16'd0, served_handle: 16'd0};
      if (it.class_id < NCLS && fill[it.class_id] < DEPTH) begin
         fifo_mem[it.class_id][wr_ptr[it.class_id]] = {it.packet_length, it.packet_handle};
         wr_ptr[it.class_id] = (wr_ptr[it.class_id] + 1) % DEPTH;
         fill[it.class_id]++;
         r.enqueue_accepted = 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int c = 0; c < NCLS; c++) begin
            credit[c] = '0;
            weight[c] = QUANTUM_RESET;
            rd_ptr[c] = 0;
            wr_ptr[c] = 0;
            fill[c]   = 0;
         end
         last_served = NO_CLASS;
         fail_count  = 0;
         pending_results.delete();
      end else begin
         if (csr_we && csr_index < CSR_REGS && csr_index < NCLS)
            weight[csr_index] = csr_wdata;
         if (req_valid && !req_stall) begin
            if (req_data.operation == OP_ENQUEUE)
               pending_results.insert(pending_results.size(), store_packet(req_data));
            else
               pending_results.insert(pending_results.size(), serve_next());
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report("result with nothing pending", 1, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.enqueue_accepted !== want.enqueue_accepted)
                  report("enqueue_accepted", rsp_data.enqueue_accepted, want.enqueue_accepted);
               if (rsp_data.packet_valid !== want.packet_valid)
                  report("packet_valid", rsp_data.packet_valid, want.packet_valid);
               if (rsp_data.served_class !== want.served_class)
                  report("served_class", rsp_data.served_class, want.served_class);
               if (rsp_data.served_length !== want.served_length)
                  report("served_length", rsp_data.served_length, want.served_length);
               if (rsp_data.served_handle !== want.served_handle)
                  report("served_handle", rsp_data.served_handle, want.served_handle);
            end
         end
      end
      outstanding = pending_results.size();
   end

endmodule

@@ tb/tb_deficit_round_robin_scheduler.sv @@
// Top of the scheduler testbench: clock, reset, stimulus, back pressure and
// the verdict. Depends on drr_pkg, drr_checker and deficit_round_robin_scheduler.
`timescale 1ns / 1ps

module tb_deficit_round_robin_scheduler;
   import drr_pkg::*;

   // Generous ceiling for the slowest legal walks here; a run has a few hundred
   // dequeues at most.
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int HOLD_CYCLES = 400;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [QUANT_W-1:0]   csr_wdata = '0;
   int                   fail_count;
   int                   outstanding;
   int                   cycles = 0;

   // When set, neither side inserts random idle cycles.
   bit                   no_idle = 1'b0;
   // Raised once to make the receiver hold off while requests keep coming.
   bit                   hold_request = 1'b0;

   always #1 clock = ~clock;

   deficit_round_robin_scheduler DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   drr_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   // Watchdog: a hung walk or a lost result ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("deficit_round_robin_scheduler: mismatch");
         $finish;
      end
   end

   // Result side back pressure. A long hold is counted here, in its own
   // process, so the request queue fills and the block stalls its input.
   always @(posedge clock) begin
      int held;
      if (hold_request) begin
         rsp_stall <= 1'b1;
         held = 0;
         while (held < HOLD_CYCLES) begin
            @(posedge clock);
            held++;
         end
         hold_request = 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 28);
      end
   end

   // Offers one item, idling first at random, and returns once req_stall reads low
   // with the item on the port. Valid stays high between back to back items unless an idle is inserted.
   task automatic send_item(input req_type it);
      while (!no_idle && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic enqueue(input int cls, input int len, input int tag);
      req_type it;
      it.operation     = OP_ENQUEUE;
      it.class_id      = 3'(cls);
      it.packet_length = 16'(len);
      it.packet_handle = 16'(tag);
      send_item(it);
   endtask

   // The other fields of a dequeue carry random junk; the block must ignore them.
   task automatic dequeue();
      req_type it;
      it = req_type'($bits(req_type)'({$urandom, $urandom}));
      it.operation = OP_DEQUEUE;
      send_item(it);
   endtask

   // Waits until every expected result has come back, plus some slack.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Loads all eight quanta; only legal while the block is idle.
   task automatic load_quanta(input logic [15:0] q [CSR_REGS]);
      for (int i = 0; i < CSR_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= q[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mixed traffic: mostly single enqueues and dequeues, with occasional
   // bursts into one class that can run it past full so refusals show up.
   task automatic random_traffic(input int count, input int max_len);
      int sent;
      int pick;
      int cls;
      int burst;
      int len;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            cls   = $urandom_range(7);
            burst = $urandom_range(60, 70);
            for (int k = 0; k < burst; k++) begin
               enqueue(cls, $urandom_range(1, max_len), $urandom);
               sent++;
            end
         end else if (pick < 52) begin
            len = ($urandom_range(99) == 0) ? 0 : $urandom_range(1, max_len);
            enqueue($urandom_range(7), len, $urandom);
            sent++;
         end else begin
            dequeue();
            sent++;
         end
      end
   endtask

   initial begin
      logic [15:0] q [CSR_REGS];

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset quanta. A dequeue with everything empty
      // must serve nothing; a zero length packet fits any deficit; the longest
      // packet needs many rounds of quantum before it goes out.
      dequeue();
      enqueue(0, 65535, 16'hFFFF);
      enqueue(0, 0, 0);
      enqueue(7, 1, 16'h0001);
      enqueue(3, 1500, 16'hA5A5);
      enqueue(5, 1501, 16'h5A5A);
      dequeue();
      dequeue();
      dequeue();
      dequeue();
      dequeue();
      dequeue();
      for (int c = 0; c < 8; c++) enqueue(c, 100 * (c + 1), c);
      for (int c = 0; c < 8; c++) dequeue();
      drain();

      // Extreme and uneven quanta with short packets. A write beyond the
      // register list must change nothing.
      q = '{16'd1, 16'd65535, 16'd2, 16'd300, 16'd1500, 16'd9000, 16'd64, 16'd40000};
      load_quanta(q);
      csr_we    <= 1'b1;
      csr_index <= CSR_IDX_W'(CSR_REGS + 1);
      csr_wdata <= 16'd1;
      @(posedge clock);
      csr_we <= 1'b0;
      hold_request = 1'b1;
      random_traffic(280, 256);
      drain();

      // Every quantum at its maximum, full range lengths; part of this phase
      // runs with no idle cycles on either side.
      for (int i = 0; i < CSR_REGS; i++) q[i] = 16'hFFFF;
      load_quanta(q);
      random_traffic(120, 65535);
      no_idle = 1'b1;
      random_traffic(100, 65535);
      no_idle = 1'b0;
      random_traffic(60, 65535);
      drain();

      // Random quanta of at least 256 with full range lengths.
      for (int i = 0; i < CSR_REGS; i++) q[i] = 16'($urandom_range(256, 65535));
      load_quanta(q);
      random_traffic(270, 65535);
      drain();

      if (fail_count == 0) begin
         $display("deficit_round_robin_scheduler: match");
      end else begin
         $display("deficit_round_robin_scheduler: mismatch");
      end
      $finish;
   end

endmodule
